// ----- hdl/sndcw_pkg.sv -----
// ----------------------------------------------------------------------------
// sndcw_pkg
// Shared constants, codes and control types of the sender congestion window.
// ----------------------------------------------------------------------------
package sndcw_pkg;

    // field widths
    localparam int SEQ_W   = 32;
    localparam int WIN_W   = 24;
    localparam int LEN_W   = 16;
    localparam int OP_W    = 2;
    localparam int DUP_W   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // divider: one quotient bit per step over the mss dividend
    localparam int DIV_STEPS = LEN_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // opcodes
    localparam logic [OP_W-1:0] OP_ACK     = 2'd0;
    localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd1;
    localparam logic [OP_W-1:0] OP_SEND    = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MSS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLIM = 2'd1;

    // reset values
    localparam logic [LEN_W-1:0] MSS_RESET  = 16'd1024;
    localparam logic [LEN_W-1:0] PLIM_RESET = 16'd1008;
    localparam logic [WIN_W-1:0] SWIN_RESET = 24'd1024;
    localparam logic [WIN_W-1:0] CWND_RESET = 24'd1;
    localparam logic [WIN_W-1:0] THR_RESET  = 24'd20480;
    localparam logic [SEQ_W-1:0] SEQ_RESET  = 32'd1;

    localparam logic [WIN_W-1:0] WIN_MAX     = {WIN_W{1'b1}};
    localparam logic [DUP_W-1:0] DUP_MAX     = 3'd7;
    localparam logic [DUP_W-1:0] DUP_TRIGGER = 3'd3;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic prep;
        logic div_start;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

// ----- hdl/sender_congestion_window.sv -----
// ----------------------------------------------------------------------------
// sender_congestion_window
// Reno-style sender window controller: acks, timeouts and segment requests.
// ----------------------------------------------------------------------------
// Flow: each item is captured, prepared and committed into the output
//   register; new acks in congestion avoidance also pass through the
//   16-step mss / cwnd divider first. The commit waits for room in the
//   output register; one item is in work at a time, and the next is taken
//   while a finished result waits in the output register.
// Reset: synchronous, active low; sets window state and configuration
//   registers to start values and clears control state, no clearing pass.
module sender_congestion_window (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sndcw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sndcw_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    // input items
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [sndcw_pkg::OP_W-1:0]         i_opcode,
    input  logic [sndcw_pkg::SEQ_W-1:0]        i_ack_seq,
    input  logic [sndcw_pkg::LEN_W-1:0]        i_ack_length,
    input  logic [sndcw_pkg::WIN_W-1:0]        i_recv_window,
    input  logic [sndcw_pkg::SEQ_W-1:0]        i_queued_end,
    // result items
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_send_valid,
    output logic [sndcw_pkg::SEQ_W-1:0]        o_segment_seq,
    output logic [sndcw_pkg::LEN_W-1:0]        o_segment_length,
    output logic                               o_timer_restart,
    output logic [sndcw_pkg::WIN_W-1:0]        o_window_now,
    output logic [sndcw_pkg::WIN_W-1:0]        o_cwnd_now,
    output logic [sndcw_pkg::WIN_W-1:0]        o_threshold_now
);

    sndcw_pkg::t_cmd    w_cmd;
    sndcw_pkg::t_status w_status;
    logic               w_busy;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_busy;

    sndcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_busy     (w_busy)
    );

    sndcw_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_opcode         (i_opcode),
        .i_ack_seq        (i_ack_seq),
        .i_ack_length     (i_ack_length),
        .i_recv_window    (i_recv_window),
        .i_queued_end     (i_queued_end),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_send_valid     (o_send_valid),
        .o_segment_seq    (o_segment_seq),
        .o_segment_length (o_segment_length),
        .o_timer_restart  (o_timer_restart),
        .o_window_now     (o_window_now),
        .o_cwnd_now       (o_cwnd_now),
        .o_threshold_now  (o_threshold_now)
    );

endmodule

// ----- hdl/sndcw_divider.sv -----
// ----------------------------------------------------------------------------
// sndcw_divider
// Restoring divider, one quotient bit per cycle, for the mss / cwnd growth.
// ----------------------------------------------------------------------------
module sndcw_divider (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [sndcw_pkg::LEN_W-1:0]    i_dividend,
    input  logic [sndcw_pkg::WIN_W-1:0]    i_divisor,
    output logic                           o_done,
    output logic [sndcw_pkg::LEN_W-1:0]    o_quotient
);

    logic                              r_busy, n_busy;
    logic                              r_have, n_have;
    logic [sndcw_pkg::DIV_CNT_W-1:0]   r_cnt, n_cnt;
    logic [sndcw_pkg::WIN_W:0]         r_rem, n_rem;
    logic [sndcw_pkg::LEN_W-1:0]       r_dvd, n_dvd;
    logic [sndcw_pkg::WIN_W-1:0]       r_dsr, n_dsr;
    logic [sndcw_pkg::WIN_W:0]         w_shift;
    logic                              w_ge;

    // shift in the next dividend bit and try the subtract
    assign w_shift = {r_rem[sndcw_pkg::WIN_W-1:0], r_dvd[sndcw_pkg::LEN_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_dsr});

    always_comb begin
        n_busy = r_busy;
        n_have = r_have;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_have = 1'b0;
            n_cnt  = sndcw_pkg::DIV_CNT_W'(sndcw_pkg::DIV_STEPS);
            n_rem  = '0;
            n_dvd  = i_dividend;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            n_rem = w_ge ? (w_shift - {1'b0, r_dsr}) : w_shift;
            n_dvd = {r_dvd[sndcw_pkg::LEN_W-2:0], w_ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == sndcw_pkg::DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_have = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_have <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_have <= n_have;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_dsr <= n_dsr;
    end

    assign o_done     = r_have & ~r_busy;
    assign o_quotient = r_dvd;

endmodule

// ----- hdl/sndcw_datapath.sv -----
// ----------------------------------------------------------------------------
// sndcw_datapath
// Window state, item capture, update arithmetic and the output register.
// ----------------------------------------------------------------------------
module sndcw_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sndcw_pkg::t_cmd                    i_cmd,
    output sndcw_pkg::t_status                 o_status,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [sndcw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sndcw_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    // item fields
    input  logic [sndcw_pkg::OP_W-1:0]         i_opcode,
    input  logic [sndcw_pkg::SEQ_W-1:0]        i_ack_seq,
    input  logic [sndcw_pkg::LEN_W-1:0]        i_ack_length,
    input  logic [sndcw_pkg::WIN_W-1:0]        i_recv_window,
    input  logic [sndcw_pkg::SEQ_W-1:0]        i_queued_end,
    // result
    input  logic                               i_out_stall,
    output logic                               o_out_valid,
    output logic                               o_send_valid,
    output logic [sndcw_pkg::SEQ_W-1:0]        o_segment_seq,
    output logic [sndcw_pkg::LEN_W-1:0]        o_segment_length,
    output logic                               o_timer_restart,
    output logic [sndcw_pkg::WIN_W-1:0]        o_window_now,
    output logic [sndcw_pkg::WIN_W-1:0]        o_cwnd_now,
    output logic [sndcw_pkg::WIN_W-1:0]        o_threshold_now
);

    localparam int SW = sndcw_pkg::SEQ_W;
    localparam int WW = sndcw_pkg::WIN_W;
    localparam int LW = sndcw_pkg::LEN_W;

    // configuration registers
    logic [LW-1:0] r_mss, r_plim;

    // window state
    logic [WW-1:0]               r_swin, n_swin;
    logic [WW-1:0]               r_cwnd, n_cwnd;
    logic [WW-1:0]               r_thr,  n_thr;
    logic [SW-1:0]               r_base, n_base;
    logic [SW-1:0]               r_nseq, n_nseq;
    logic [sndcw_pkg::DUP_W-1:0] r_dup,  n_dup;

    // captured item and prepared terms
    logic [sndcw_pkg::OP_W-1:0] r_op;
    logic [SW-1:0]              r_aseq, r_qend;
    logic [LW-1:0]              r_alen;
    logic [WW-1:0]              r_rwin;
    logic                       r_is_new, r_slow;
    logic [SW:0]                r_limit;

    // output register
    logic          r_out_valid;
    logic          r_send_valid, n_send_valid;
    logic [SW-1:0] r_seg_seq,    n_seg_seq;
    logic [LW-1:0] r_seg_len,    n_seg_len;
    logic          r_timer,      n_timer;

    logic          w_is_new, w_slow;
    logic          w_div_done;
    logic [LW-1:0] w_quot;

    // classify the captured item
    assign w_is_new = (r_aseq >= r_base);
    assign w_slow   = (r_cwnd < r_thr) || (r_cwnd == '0);

    assign o_status.need_div = (r_op == sndcw_pkg::OP_ACK) && w_is_new && !w_slow;
    assign o_status.div_done = w_div_done;
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    sndcw_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_mss),
        .i_divisor  (r_cwnd),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // update terms
    logic [WW:0]             w_sum;
    logic [WW-1:0]           w_add;
    logic [sndcw_pkg::DUP_W-1:0] w_dup_inc;
    logic [WW-1:0]           w_thr_half;
    logic [SW:0]             w_seq33, w_qend33, w_top, w_len33;
    logic                    w_room;
    logic [LW-1:0]           w_len;

    assign w_add      = r_slow ? {{(WW-LW){1'b0}}, r_mss} : {{(WW-LW){1'b0}}, w_quot};
    assign w_sum      = {1'b0, r_cwnd} + {1'b0, w_add};
    assign w_dup_inc  = (r_dup < sndcw_pkg::DUP_MAX) ? r_dup + 1'b1 : r_dup;
    assign w_thr_half = r_thr >> 1;

    assign w_seq33  = {1'b0, r_nseq};
    assign w_qend33 = {1'b0, r_qend};
    assign w_room   = (w_seq33 < r_limit) && (r_nseq <= r_qend);
    assign w_top    = (r_limit < w_qend33) ? r_limit : w_qend33;
    assign w_len33  = w_top - w_seq33;
    assign w_len    = (w_len33 > {{(SW+1-LW){1'b0}}, r_plim}) ? r_plim : w_len33[LW-1:0];

    // next state and result of the item
    always_comb begin
        n_swin       = r_swin;
        n_cwnd       = r_cwnd;
        n_thr        = r_thr;
        n_base       = r_base;
        n_nseq       = r_nseq;
        n_dup        = r_dup;
        n_send_valid = 1'b0;
        n_seg_seq    = '0;
        n_seg_len    = '0;
        n_timer      = 1'b0;
        unique case (r_op)
            sndcw_pkg::OP_ACK: begin
                if (r_is_new) begin
                    n_base = r_aseq + {{(SW-LW){1'b0}}, r_alen};
                    n_cwnd = w_sum[WW] ? sndcw_pkg::WIN_MAX : w_sum[WW-1:0];
                    n_dup  = '0;
                end else begin
                    n_dup = w_dup_inc;
                    if (w_dup_inc == sndcw_pkg::DUP_TRIGGER) begin
                        n_thr  = w_thr_half;
                        n_cwnd = w_thr_half;
                    end
                end
                n_swin  = (r_rwin < n_cwnd) ? r_rwin : n_cwnd;
                n_timer = (n_base != r_nseq);
            end
            sndcw_pkg::OP_TIMEOUT: begin
                n_thr   = w_thr_half;
                n_cwnd  = {{(WW-LW){1'b0}}, r_mss};
                n_timer = 1'b1;
            end
            sndcw_pkg::OP_SEND: begin
                if (w_room && (w_len != '0)) begin
                    n_send_valid = 1'b1;
                    n_seg_seq    = r_nseq;
                    n_seg_len    = w_len;
                    n_timer      = (r_base == r_nseq);
                    n_nseq       = r_nseq + {{(SW-LW){1'b0}}, w_len};
                end
            end
            sndcw_pkg::OP_NONE: begin
            end
            default: begin
            end
        endcase
    end

    // configuration and window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mss  <= sndcw_pkg::MSS_RESET;
            r_plim <= sndcw_pkg::PLIM_RESET;
            r_swin <= sndcw_pkg::SWIN_RESET;
            r_cwnd <= sndcw_pkg::CWND_RESET;
            r_thr  <= sndcw_pkg::THR_RESET;
            r_base <= sndcw_pkg::SEQ_RESET;
            r_nseq <= sndcw_pkg::SEQ_RESET;
            r_dup  <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_index == sndcw_pkg::CFG_MSS)) begin
                r_mss <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_index == sndcw_pkg::CFG_PLIM)) begin
                r_plim <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                r_swin <= n_swin;
                r_cwnd <= n_cwnd;
                r_thr  <= n_thr;
                r_base <= n_base;
                r_nseq <= n_nseq;
                r_dup  <= n_dup;
            end
        end
    end

    // capture the item, then hold the prepared terms
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_opcode;
            r_aseq <= i_ack_seq;
            r_alen <= i_ack_length;
            r_rwin <= i_recv_window;
            r_qend <= i_queued_end;
        end
        if (i_cmd.prep) begin
            r_is_new <= w_is_new;
            r_slow   <= w_slow;
            r_limit  <= {1'b0, r_base} + {{(SW+1-WW){1'b0}}, r_swin};
        end
    end

    // output register: load on commit, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.commit) begin
            r_send_valid <= n_send_valid;
            r_seg_seq    <= n_seg_seq;
            r_seg_len    <= n_seg_len;
            r_timer      <= n_timer;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_send_valid     = r_send_valid;
    assign o_segment_seq    = r_seg_seq;
    assign o_segment_length = r_seg_len;
    assign o_timer_restart  = r_timer;
    assign o_window_now     = r_swin;
    assign o_cwnd_now       = r_cwnd;
    assign o_threshold_now  = r_thr;

endmodule

// ----- hdl/sndcw_ctrl.sv -----
// ----------------------------------------------------------------------------
// sndcw_ctrl
// Sequencer: capture, prepare, optional divide, then commit into the output.
// ----------------------------------------------------------------------------
module sndcw_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  sndcw_pkg::t_status   i_status,
    output sndcw_pkg::t_cmd      o_cmd,
    output logic                 o_busy
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state         = r_state;
        o_cmd.capture   = 1'b0;
        o_cmd.prep      = 1'b0;
        o_cmd.div_start = 1'b0;
        o_cmd.commit    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                if (i_status.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // wait for room in the output register
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- hdl/sndcw_checker.sv -----
// ----------------------------------------------------------------------------
// sndcw_checker
// Port-level checks of the sender window controller, bound to the top level.
// ----------------------------------------------------------------------------
module sndcw_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_stall,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  logic                          o_send_valid,
    input  logic [sndcw_pkg::SEQ_W-1:0]   o_segment_seq,
    input  logic [sndcw_pkg::LEN_W-1:0]   o_segment_length
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_segment_seq)
            && $stable(o_segment_length) && $stable(o_send_valid))
        else $error("stalled result changed");

    // block is busy right after taking an item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("item accepted while previous still in work");

    // a result without a grant carries empty segment fields
    a_no_grant_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_send_valid |-> (o_segment_length == '0)
            && (o_segment_seq == '0))
        else $error("segment fields set without grant");

    // a grant always carries payload
    a_grant_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_send_valid |-> (o_segment_length != '0))
        else $error("grant with zero length");

endmodule

bind sender_congestion_window sndcw_checker u_sndcw_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_send_valid     (o_send_valid),
    .o_segment_seq    (o_segment_seq),
    .o_segment_length (o_segment_length)
);

// ----- sim/sender_congestion_window_test.sv -----
// ----------------------------------------------------------------------------
// sender_congestion_window_test
// Self-checking bench for the sender congestion window. Items flow through
// the valid/stall channels with bursty sending and a patterned receiver
// stall. Every accepted item updates a local window model. That model gives
// the one expected result, and each delivered result is compared field by
// field. The mss and payload limit registers are rewritten between phases.
// ----------------------------------------------------------------------------
module sender_congestion_window_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SEQ_W     = sndcw_pkg::SEQ_W;
    localparam int WIN_W     = sndcw_pkg::WIN_W;
    localparam int LEN_W     = sndcw_pkg::LEN_W;
    localparam int OP_W      = sndcw_pkg::OP_W;
    localparam int DUP_W     = sndcw_pkg::DUP_W;
    localparam int CFG_IDX_W = sndcw_pkg::CFG_IDX_W;
    localparam int CFG_DAT_W = sndcw_pkg::CFG_DAT_W;

    localparam int          N_PHASES    = 6;
    localparam int          HOLD_CYCLES = 400;
    localparam int          SETTLE      = 25;
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [SEQ_W-1:0] ack_seq;
        logic [LEN_W-1:0] ack_length;
        logic [WIN_W-1:0] recv_window;
        logic [SEQ_W-1:0] queued_end;
    } t_cw_item;

    typedef struct packed {
        logic             send_valid;
        logic [SEQ_W-1:0] seg_seq;
        logic [LEN_W-1:0] seg_len;
        logic             timer_restart;
        logic [WIN_W-1:0] window;
        logic [WIN_W-1:0] cwnd;
        logic [WIN_W-1:0] thresh;
    } t_cw_result;

    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    // DUT ports
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = sndcw_pkg::CFG_MSS;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [OP_W-1:0]      i_opcode = sndcw_pkg::OP_NONE;
    logic [SEQ_W-1:0]     i_ack_seq = '0;
    logic [LEN_W-1:0]     i_ack_length = '0;
    logic [WIN_W-1:0]     i_recv_window = '0;
    logic [SEQ_W-1:0]     i_queued_end = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_send_valid;
    logic [SEQ_W-1:0]     o_segment_seq;
    logic [LEN_W-1:0]     o_segment_length;
    logic                 o_timer_restart;
    logic [WIN_W-1:0]     o_window_now;
    logic [WIN_W-1:0]     o_cwnd_now;
    logic [WIN_W-1:0]     o_threshold_now;

    // window model state and register copies
    logic [WIN_W-1:0] mdl_swnd;
    logic [WIN_W-1:0] mdl_cwnd;
    logic [WIN_W-1:0] mdl_thr;
    logic [SEQ_W-1:0] mdl_base;
    logic [SEQ_W-1:0] mdl_nseq;
    logic [DUP_W-1:0] mdl_dups;
    logic [LEN_W-1:0] cfg_mss;
    logic [LEN_W-1:0] cfg_plim;

    t_cw_item   pending_q[$];
    t_cw_result expected_q[$];
    t_cw_item   offered;
    t_cw_result mon_got;
    t_cw_result mon_want;

    logic        item_taken;
    int          burst_left = 1;
    int          gap_left = 0;
    int          dup_run = 0;
    int          errors = 0;
    int          items_taken = 0;
    int          results_checked = 0;
    int          grants_seen = 0;
    int unsigned cycles = 0;
    int          rx_cycle = 0;
    t_rx_mode    rx_mode = RX_FREE;
    logic        hold_go = 1'b0;
    logic        hold_done = 1'b0;
    int          hold_left = 0;

    sender_congestion_window i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_ack_seq        (i_ack_seq),
        .i_ack_length     (i_ack_length),
        .i_recv_window    (i_recv_window),
        .i_queued_end     (i_queued_end),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_send_valid     (o_send_valid),
        .o_segment_seq    (o_segment_seq),
        .o_segment_length (o_segment_length),
        .o_timer_restart  (o_timer_restart),
        .o_window_now     (o_window_now),
        .o_cwnd_now       (o_cwnd_now),
        .o_threshold_now  (o_threshold_now)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Apply one item to the window model and return the result it should give
    function automatic t_cw_result advance_window(input t_cw_item it);
        t_cw_result       r;
        logic [WIN_W-1:0] growth;
        logic [WIN_W:0]   grown;
        logic [SEQ_W:0]   win_end;
        logic [SEQ_W:0]   top;
        logic [SEQ_W:0]   len;
        r = '0;
        case (it.opcode)
            sndcw_pkg::OP_ACK: begin
                if (it.ack_seq >= mdl_base) begin
                    // new ack: move the base, grow the window
                    mdl_base = it.ack_seq + SEQ_W'(it.ack_length);
                    if (mdl_cwnd < mdl_thr || mdl_cwnd == '0) begin
                        growth = WIN_W'(cfg_mss);
                    end else begin
                        growth = WIN_W'(cfg_mss) / mdl_cwnd;
                    end
                    grown    = {1'b0, mdl_cwnd} + {1'b0, growth};
                    mdl_cwnd = grown[WIN_W] ? sndcw_pkg::WIN_MAX : grown[WIN_W-1:0];
                    mdl_dups = '0;
                end else begin
                    // duplicate: halve only on the third one
                    if (mdl_dups < sndcw_pkg::DUP_MAX) mdl_dups = mdl_dups + 1'b1;
                    if (mdl_dups == sndcw_pkg::DUP_TRIGGER) begin
                        mdl_thr  = mdl_thr >> 1;
                        mdl_cwnd = mdl_thr;
                    end
                end
                mdl_swnd = (it.recv_window < mdl_cwnd) ? it.recv_window : mdl_cwnd;
                r.timer_restart = (mdl_base != mdl_nseq);
            end
            sndcw_pkg::OP_TIMEOUT: begin
                mdl_thr  = mdl_thr >> 1;
                mdl_cwnd = WIN_W'(cfg_mss);
                r.timer_restart = 1'b1;
            end
            sndcw_pkg::OP_SEND: begin
                // grant up to the window edge, the queued data or the payload limit, no wrap
                win_end = {1'b0, mdl_base} + (SEQ_W+1)'(mdl_swnd);
                if ({1'b0, mdl_nseq} < win_end && mdl_nseq <= it.queued_end) begin
                    top = (win_end < {1'b0, it.queued_end}) ? win_end : {1'b0, it.queued_end};
                    len = top - {1'b0, mdl_nseq};
                    if (len > (SEQ_W+1)'(cfg_plim)) len = (SEQ_W+1)'(cfg_plim);
                    if (len != '0) begin
                        r.send_valid    = 1'b1;
                        r.seg_seq       = mdl_nseq;
                        r.seg_len       = len[LEN_W-1:0];
                        r.timer_restart = (mdl_base == mdl_nseq);
                        mdl_nseq        = mdl_nseq + len[SEQ_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        r.window = mdl_swnd;
        r.cwnd   = mdl_cwnd;
        r.thresh = mdl_thr;
        return r;
    endfunction

    function automatic t_cw_item make_item(input logic [OP_W-1:0] op,
                                           input logic [SEQ_W-1:0] seq,
                                           input logic [LEN_W-1:0] len,
                                           input logic [WIN_W-1:0] rwin,
                                           input logic [SEQ_W-1:0] qend);
        t_cw_item it;
        it.opcode      = op;
        it.ack_seq     = seq;
        it.ack_length  = len;
        it.recv_window = rwin;
        it.queued_end  = qend;
        return it;
    endfunction

    // Build a mostly well-formed item from the current model state
    function automatic t_cw_item next_random_item();
        t_cw_item         it;
        int               pick;
        logic [SEQ_W-1:0] in_flight;
        it.opcode      = sndcw_pkg::OP_ACK;
        it.ack_seq     = $urandom;
        it.ack_length  = LEN_W'($urandom);
        it.recv_window = WIN_W'($urandom);
        it.queued_end  = $urandom;
        in_flight      = mdl_nseq - mdl_base;
        pick           = $urandom_range(0, 99);
        if (dup_run == 0 && pick >= 65 && pick < 78) dup_run = $urandom_range(2, 6);
        if (dup_run > 0) begin
            // duplicate ack just below the base
            dup_run--;
            it.ack_seq = (mdl_base > 1000) ? mdl_base - $urandom_range(1, 1000) : '0;
            it.ack_length = LEN_W'($urandom_range(0, 1500));
        end else if (pick < 35) begin
            it.opcode = sndcw_pkg::OP_SEND;
            if (pick >= 3) it.queued_end = mdl_nseq + $urandom_range(0, 4000);
        end else if (pick < 65) begin
            // ack at or just past the base, covering part of the data in flight
            it.ack_seq = mdl_base + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 200) : 0);
            it.ack_length = (in_flight < 65536) ? LEN_W'($urandom_range(0, in_flight))
                                                 : LEN_W'($urandom);
            case ($urandom_range(0, 9))
                0:       it.recv_window = '0;
                1:       it.recv_window = sndcw_pkg::WIN_MAX;
                2:       it.recv_window = WIN_W'($urandom_range(0, 2000));
                default: it.recv_window = WIN_W'($urandom_range(0, 200000));
            endcase
        end else if (pick < 83) begin
            it.opcode = sndcw_pkg::OP_TIMEOUT;
        end else begin
            it.opcode = OP_W'($urandom_range(0, 3));
        end
        return it;
    endfunction

    // Edge cases: empty and refused grants, payload cap, dup counting and
    // saturation, zero receiver window, unused opcode, sequence wrap and
    // growth in congestion avoidance
    task automatic push_directed();
        pending_q.push_back(make_item(sndcw_pkg::OP_SEND, '0, '0, '0, 32'd1));
        pending_q.push_back(make_item(sndcw_pkg::OP_SEND, '0, '0, '0, '0));
        repeat (3) pending_q.push_back(make_item(sndcw_pkg::OP_SEND, '0, '0, '0, '1));
        pending_q.push_back(make_item(sndcw_pkg::OP_ACK, 32'd1, 16'd1008,
                                      sndcw_pkg::WIN_MAX, '0));
        repeat (8) pending_q.push_back(make_item(sndcw_pkg::OP_ACK, '0, '0,
                                                 sndcw_pkg::WIN_MAX, '0));
        pending_q.push_back(make_item(sndcw_pkg::OP_ACK, 32'd1009, 16'd16, '0, '0));
        pending_q.push_back(make_item(sndcw_pkg::OP_SEND, '0, '0, '0, '1));
        pending_q.push_back(make_item(sndcw_pkg::OP_NONE, '1, '1, '1, '1));
        pending_q.push_back(make_item(sndcw_pkg::OP_TIMEOUT, '0, '0, '0, '0));
        pending_q.push_back(make_item(sndcw_pkg::OP_ACK, '1, '1, sndcw_pkg::WIN_MAX, '0));
        pending_q.push_back(make_item(sndcw_pkg::OP_ACK, '1, '0, sndcw_pkg::WIN_MAX, '0));
        pending_q.push_back(make_item(sndcw_pkg::OP_SEND, '0, '0, '0, '1));
        repeat (3) pending_q.push_back(make_item(sndcw_pkg::OP_TIMEOUT, '0, '0, '0, '0));
        pending_q.push_back(make_item(sndcw_pkg::OP_ACK, '1, 16'd1,
                                      sndcw_pkg::WIN_MAX, '0));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == sndcw_pkg::CFG_MSS) cfg_mss = val;
        else if (idx == sndcw_pkg::CFG_PLIM) cfg_plim = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Keep at most two items waiting so each one sees a fresh model state
    task automatic run_random(input int count);
        for (int k = 0; k < count; k++) begin
            while (pending_q.size() >= 2) @(negedge i_clk);
            pending_q.push_back(next_random_item());
        end
    endtask

    // Wait for all items to be taken and answered, then let the block settle
    task automatic drain();
        do @(negedge i_clk);
        while (pending_q.size() != 0 || i_in_valid || expected_q.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [SEQ_W-1:0] want,
                               input logic [SEQ_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Sender: take on handshake, then present the next item in bursts
    always begin : feed_items
        @(posedge i_clk);
        item_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (item_taken) begin
            expected_q.push_back(advance_window(offered));
            items_taken++;
        end
        @(negedge i_clk);
        if (item_taken || !i_in_valid) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                offered = pending_q.pop_front();
                i_opcode      <= offered.opcode;
                i_ack_seq     <= offered.ack_seq;
                i_ack_length  <= offered.ack_length;
                i_recv_window <= offered.recv_window;
                i_queued_end  <= offered.queued_end;
                i_in_valid    <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall on a changing pattern, plus one long hold-off on request
    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 97 == 0) rx_mode = t_rx_mode'($urandom_range(0, 3));
        if (hold_go && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (rx_mode)
                RX_FREE:  i_out_stall <= 1'b0;
                RX_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                default:  i_out_stall <= (rx_cycle % 7 < 3);
            endcase
        end
    end

    // Compare each delivered result against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            mon_got.send_valid    = o_send_valid;
            mon_got.seg_seq       = o_segment_seq;
            mon_got.seg_len       = o_segment_length;
            mon_got.timer_restart = o_timer_restart;
            mon_got.window        = o_window_now;
            mon_got.cwnd          = o_cwnd_now;
            mon_got.thresh        = o_threshold_now;
            if (expected_q.size() == 0) begin
                $display("%0t: result item with nothing expected", $time);
                errors++;
            end else begin
                mon_want = expected_q.pop_front();
                check_field("send_valid", SEQ_W'(mon_want.send_valid),
                            SEQ_W'(mon_got.send_valid));
                check_field("segment_seq", mon_want.seg_seq, mon_got.seg_seq);
                check_field("segment_length", SEQ_W'(mon_want.seg_len),
                            SEQ_W'(mon_got.seg_len));
                check_field("timer_restart", SEQ_W'(mon_want.timer_restart),
                            SEQ_W'(mon_got.timer_restart));
                check_field("window_now", SEQ_W'(mon_want.window),
                            SEQ_W'(mon_got.window));
                check_field("cwnd_now", SEQ_W'(mon_want.cwnd), SEQ_W'(mon_got.cwnd));
                check_field("threshold_now", SEQ_W'(mon_want.thresh),
                            SEQ_W'(mon_got.thresh));
                results_checked++;
                if (mon_want.send_valid) grants_seen++;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results pending", cycles,
                     expected_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        logic [LEN_W-1:0] phase_mss [N_PHASES];
        logic [LEN_W-1:0] phase_plim[N_PHASES];
        int               phase_items[N_PHASES];
        phase_mss   = '{16'd1024, 16'd65535, 16'd1, 16'd0, 16'd0, 16'd536};
        phase_plim  = '{16'd1008, 16'd65535, 16'd1, 16'd0, 16'd0, 16'd1460};
        phase_items = '{400, 350, 250, 100, 400, 450};
        phase_mss[4]  = LEN_W'($urandom_range(1, 65535));
        phase_plim[4] = LEN_W'($urandom_range(1, 65535));

        // reset the model alongside the block
        cfg_mss  = sndcw_pkg::MSS_RESET;
        cfg_plim = sndcw_pkg::PLIM_RESET;
        mdl_swnd = sndcw_pkg::SWIN_RESET;
        mdl_cwnd = sndcw_pkg::CWND_RESET;
        mdl_thr  = sndcw_pkg::THR_RESET;
        mdl_base = sndcw_pkg::SEQ_RESET;
        mdl_nseq = sndcw_pkg::SEQ_RESET;
        mdl_dups = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_reg(sndcw_pkg::CFG_MSS, phase_mss[ph]);
            write_reg(sndcw_pkg::CFG_PLIM, phase_plim[ph]);
            if (ph == 0) push_directed();
            if (ph == 1) hold_go = 1'b1;
            run_random(phase_items[ph]);
            drain();
        end

        if (expected_q.size() != 0) errors++;
        $display("Covered %0d items over %0d register settings, incl. a %0d-cycle hold-off.",
                 items_taken, N_PHASES, HOLD_CYCLES);
        $display("Checked %0d results, %0d of them segment grants; %0d mismatches.",
                 results_checked, grants_seen, errors);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/sndcw_pkg.sv
hdl/sndcw_divider.sv
hdl/sndcw_datapath.sv
hdl/sndcw_ctrl.sv
hdl/sender_congestion_window.sv
hdl/sndcw_checker.sv
sim/sender_congestion_window_test.sv
